// ----- sv/tard_pkg.sv -----
package tard_pkg;

  localparam logic [7:0]  HDR_TYPE      = 8'h17;
  localparam logic [7:0]  HDR_VER       = 8'h03;
  localparam int          HDR_BYTES     = 5;
  localparam logic [15:0] MAX_LEN_RESET = 16'd16384;

  localparam int HDR_POS_W = $clog2(HDR_BYTES);

  // One result per input byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       frame_error;
  } tard_result_t;

endpackage

// ----- sv/tard_core.sv -----
module tard_core
  import tard_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   in_byte,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  output tard_result_t result
);

  localparam logic [HDR_POS_W-1:0] POS_TYPE   = HDR_POS_W'(0);
  localparam logic [HDR_POS_W-1:0] POS_LEN_HI = HDR_POS_W'(3);
  localparam logic [HDR_POS_W-1:0] POS_LEN_LO = HDR_POS_W'(4);

  logic [15:0]          max_record_len;
  logic [HDR_POS_W-1:0] header_pos;
  logic [HDR_POS_W-1:0] header_pos_next;
  logic [7:0]           length_high;
  logic [7:0]           length_high_next;
  logic [15:0]          payload_left;
  logic [15:0]          payload_left_next;
  logic                 error_seen;
  logic                 error_seen_next;
  logic [15:0]          rec_len;
  logic [7:0]           hdr_want;

  assign rec_len  = {length_high, in_byte};
  assign hdr_want = (header_pos == POS_TYPE) ? HDR_TYPE : HDR_VER;

  always_comb begin
    header_pos_next   = header_pos;
    length_high_next  = length_high;
    payload_left_next = payload_left;
    error_seen_next   = error_seen;
    result.out_byte      = 8'd0;
    result.payload_valid = 1'b0;
    if (!error_seen) begin
      if (payload_left != 16'd0) begin
        result.out_byte      = in_byte;
        result.payload_valid = 1'b1;
        payload_left_next    = payload_left - 16'd1;
      end else if (header_pos < POS_LEN_HI) begin
        if (in_byte != hdr_want) begin
          error_seen_next = 1'b1;
        end else begin
          header_pos_next = header_pos + HDR_POS_W'(1);
        end
      end else if (header_pos == POS_LEN_HI) begin
        length_high_next = in_byte;
        header_pos_next  = POS_LEN_LO;
      end else begin
        // length low byte: close the header, zero length skips straight to next header
        header_pos_next = POS_TYPE;
        if (rec_len > max_record_len) begin
          error_seen_next = 1'b1;
        end else begin
          payload_left_next = rec_len;
        end
      end
    end
    result.frame_error = error_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_len <= MAX_LEN_RESET;
      header_pos     <= POS_TYPE;
      length_high    <= 8'd0;
      payload_left   <= 16'd0;
      error_seen     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_record_len <= cfg_wdata;
      end
      if (accept) begin
        header_pos   <= header_pos_next;
        length_high  <= length_high_next;
        payload_left <= payload_left_next;
        error_seen   <= error_seen_next;
      end
    end
  end

endmodule

// ----- sv/tard_out_buf.sv -----
module tard_out_buf
  import tard_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tard_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output tard_result_t out_data
);

  logic         main_valid;
  tard_result_t main_data;
  logic         skid_valid;
  tard_result_t skid_data;
  logic         pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      // skid is empty whenever push is allowed
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_valid || pop) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      main_data <= skid_data;
    end
  end

endmodule

// ----- sv/tls_app_record_deframer_unit.sv -----
// Strips TLS application-data record framing from a byte stream (0x17 0x03 0x03, then a
// big-endian 16-bit length) and passes payload bytes on, one result per input byte. The
// unit takes one byte every cycle while in_stall is low; the per-byte header/length state
// update is the only step between input and the output buffer's result register. A two-entry
// output register (result plus skid) keeps input flowing while a result waits, so in_stall
// rises only after the output side has been stalled with both entries full. A bad header byte
// or a length above max_record_len sets frame_error, which stays set and blocks all payload
// until rst. Users must write max_record_len (cfg_we/cfg_wdata) only while idle; unenforced.
module tls_app_record_deframer_unit
  import tard_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        payload_valid,
  output logic        frame_error,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic         accept;
  logic         buf_full;
  tard_result_t core_result;
  tard_result_t out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  tard_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (core_result)
  );

  tard_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_byte      = out_data.out_byte;
  assign payload_valid = out_data.payload_valid;
  assign frame_error   = out_data.frame_error;

endmodule

// ----- sv/tard_checker.sv -----
module tard_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        payload_valid,
  input logic        frame_error,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata
);

  // no payload once the error is up
  a_err_blocks_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_error |-> !payload_valid)
    else $error("payload passed with frame_error set");

  // swallowed bytes carry zero data
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> out_byte == 8'd0)
    else $error("non-payload result with nonzero byte");

  // a result with the error is followed by no result or by one with the error still set
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_error |=> !out_valid || frame_error)
    else $error("frame_error dropped before reset");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !in_stall)
    else $error("results present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(payload_valid)
      && $stable(frame_error))
    else $error("stalled result changed");

endmodule

bind tls_app_record_deframer_unit tard_checker u_tard_checker (.*);
